### src/dqds_pkg.sv
package dqds_pkg;

    localparam int CountW = 32;
    localparam int TickW  = 16;
    localparam int ScaleW = 32;
    localparam int CfgW   = 32;
    localparam int ProdW  = CountW + ScaleW + 1;

    localparam logic [TickW-1:0]  INTERVAL_RESET = 16'd100;
    localparam logic [ScaleW-1:0] SCALE_RESET    = 32'h0001_0000;
    localparam logic [1:0]        ENC_STATE_RESET = 2'b11;

    typedef enum logic [0:0] {
        REG_INTERVAL = 1'b0,
        REG_SCALE    = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } step_t;

    // x4 decode, indexed by {previous A,B, current A,B}
    localparam step_t QUAD_TABLE [16] = '{
        STEP_HOLD, STEP_UP,   STEP_DOWN, STEP_HOLD,
        STEP_DOWN, STEP_HOLD, STEP_HOLD, STEP_UP,
        STEP_UP,   STEP_HOLD, STEP_HOLD, STEP_DOWN,
        STEP_HOLD, STEP_DOWN, STEP_UP,   STEP_HOLD
    };

    typedef struct packed {
        logic enc1_a;
        logic enc1_b;
        logic enc2_a;
        logic enc2_b;
        logic tick;
    } sample_t;

    typedef struct packed {
        logic [CountW-1:0] count_one;
        logic [CountW-1:0] count_two;
        logic [CountW-1:0] delta_one;
        logic [CountW-1:0] delta_two;
        logic              updated;
    } track_t;

    function automatic logic [CountW-1:0] step_value(input step_t s);
        logic [CountW-1:0] v;
        case (s)
            STEP_UP:   v = {{(CountW-1){1'b0}}, 1'b1};
            STEP_DOWN: v = {CountW{1'b1}};
            default:   v = '0;
        endcase
        return v;
    endfunction

endpackage

### src/dqds_track.sv
module dqds_track (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  dqds_pkg::sample_t             sample,
    input  logic [dqds_pkg::TickW-1:0]    interval,
    output dqds_pkg::track_t              trk
);
    import dqds_pkg::*;

    logic [1:0]        prev_one_reg, prev_two_reg;
    logic [CountW-1:0] pos_one_reg, pos_two_reg;
    logic [CountW-1:0] dlt_one_reg, dlt_two_reg;
    logic [TickW-1:0]  tick_reg;
    track_t            trk_reg;

    logic [1:0]        cur_one, cur_two;
    logic [CountW-1:0] inc_one, inc_two;
    logic [CountW-1:0] pos_one_next, pos_two_next;
    logic [CountW-1:0] dlt_one_sum, dlt_two_sum;
    logic [CountW-1:0] dlt_one_next, dlt_two_next;
    logic [TickW:0]    cnt_sum;
    logic [TickW-1:0]  limit;
    logic              hit;
    logic [TickW-1:0]  tick_next;
    track_t            trk_next;

    always_comb
    begin
        cur_one = {sample.enc1_a, sample.enc1_b};
        cur_two = {sample.enc2_a, sample.enc2_b};
        inc_one = step_value(QUAD_TABLE[{prev_one_reg, cur_one}]);
        inc_two = step_value(QUAD_TABLE[{prev_two_reg, cur_two}]);
        pos_one_next = pos_one_reg + inc_one;
        pos_two_next = pos_two_reg + inc_two;
        // running distance since the last snapshot
        dlt_one_sum = dlt_one_reg + inc_one;
        dlt_two_sum = dlt_two_reg + inc_two;

        cnt_sum = {1'b0, tick_reg} + {{TickW{1'b0}}, 1'b1};
        limit   = (interval == '0) ? {{(TickW-1){1'b0}}, 1'b1} : interval;
        hit     = sample.tick && (cnt_sum >= {1'b0, limit});

        if (hit)
            tick_next = '0;
        else if (sample.tick)
            tick_next = cnt_sum[TickW-1:0];
        else
            tick_next = tick_reg;

        dlt_one_next = hit ? '0 : dlt_one_sum;
        dlt_two_next = hit ? '0 : dlt_two_sum;

        trk_next.count_one = pos_one_next;
        trk_next.count_two = pos_two_next;
        trk_next.delta_one = dlt_one_sum;
        trk_next.delta_two = dlt_two_sum;
        trk_next.updated   = hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_one_reg <= ENC_STATE_RESET;
            prev_two_reg <= ENC_STATE_RESET;
            pos_one_reg  <= '0;
            pos_two_reg  <= '0;
            dlt_one_reg  <= '0;
            dlt_two_reg  <= '0;
            tick_reg     <= '0;
            trk_reg      <= '0;
        end
        else if (advance)
        begin
            prev_one_reg <= cur_one;
            prev_two_reg <= cur_two;
            pos_one_reg  <= pos_one_next;
            pos_two_reg  <= pos_two_next;
            dlt_one_reg  <= dlt_one_next;
            dlt_two_reg  <= dlt_two_next;
            tick_reg     <= tick_next;
            trk_reg      <= trk_next;
        end
    end

    assign trk = trk_reg;

endmodule

### src/dqds_speed.sv
module dqds_speed (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  dqds_pkg::track_t               trk,
    input  logic [dqds_pkg::ScaleW-1:0]    scale,
    output logic [dqds_pkg::CountW-1:0]    count_one,
    output logic [dqds_pkg::CountW-1:0]    count_two,
    output logic [dqds_pkg::CountW-1:0]    speed_one,
    output logic [dqds_pkg::CountW-1:0]    speed_two,
    output logic                           speed_updated
);
    import dqds_pkg::*;

    logic [CountW-1:0]       cnt_one_reg, cnt_two_reg;
    logic [CountW-1:0]       vel_one_reg, vel_two_reg;
    logic                    upd_reg;
    logic signed [ProdW-1:0] prod_one, prod_two;
    logic [CountW-1:0]       vel_one_next, vel_two_next;

    function automatic logic [CountW-1:0] saturate(input logic signed [ProdW-1:0] p);
        logic [CountW-1:0] r;
        // in range when every bit above bit 30 matches the sign
        if ((p[ProdW-1:CountW-1] == '0) || (p[ProdW-1:CountW-1] == '1))
            r = p[CountW-1:0];
        else if (p[ProdW-1])
            r = {1'b1, {(CountW-1){1'b0}}};
        else
            r = {1'b0, {(CountW-1){1'b1}}};
        return r;
    endfunction

    always_comb
    begin
        prod_one = $signed(trk.delta_one) * $signed({1'b0, scale});
        prod_two = $signed(trk.delta_two) * $signed({1'b0, scale});
        vel_one_next = trk.updated ? saturate(prod_one) : vel_one_reg;
        vel_two_next = trk.updated ? saturate(prod_two) : vel_two_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_one_reg <= '0;
            vel_two_reg <= '0;
            upd_reg     <= 1'b0;
        end
        else if (load)
        begin
            vel_one_reg <= vel_one_next;
            vel_two_reg <= vel_two_next;
            upd_reg     <= trk.updated;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cnt_one_reg <= trk.count_one;
            cnt_two_reg <= trk.count_two;
        end
    end

    assign count_one     = cnt_one_reg;
    assign count_two     = cnt_two_reg;
    assign speed_one     = vel_one_reg;
    assign speed_two     = vel_two_reg;
    assign speed_updated = upd_reg;

endmodule

### src/dual_quadrature_decoder_speed_top.sv
// Stages: input register, decode/track register, multiply/saturate result register.
// Throughput: one sample per cycle unless out_ready holds the pipeline; the two 32x33 speed
// multipliers sit alone in the last stage.
// Reset (rst_n low, asynchronous): both encoder states 11, counts, snapshots, tick count
// and speeds cleared, interval 100 ticks, scale 1.0 in Q16.16, pipeline empty.
module dual_quadrature_decoder_speed_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [0:0]                     cfg_index,
    input  logic [dqds_pkg::CfgW-1:0]      cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           enc1_a,
    input  logic                           enc1_b,
    input  logic                           enc2_a,
    input  logic                           enc2_b,
    input  logic                           tick,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [dqds_pkg::CountW-1:0] count_one,
    output logic signed [dqds_pkg::CountW-1:0] count_two,
    output logic signed [dqds_pkg::CountW-1:0] speed_one,
    output logic signed [dqds_pkg::CountW-1:0] speed_two,
    output logic                           speed_updated
);
    import dqds_pkg::*;

    logic [TickW-1:0]  interval_reg;
    logic [ScaleW-1:0] scale_reg;
    sample_t           smp_reg;
    logic              a_vld_reg, b_vld_reg, out_vld_reg;
    logic              a_vld_next, b_vld_next, out_vld_next;
    logic              ready_b, ready_c, adv_b, adv_c, accept;
    track_t            trk;
    logic [CountW-1:0] cnt_one_w, cnt_two_w, spd_one_w, spd_two_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= INTERVAL_RESET;
            scale_reg    <= SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_INTERVAL: interval_reg <= cfg_data[TickW-1:0];
                REG_SCALE:    scale_reg    <= cfg_data[ScaleW-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        ready_c  = !out_vld_reg || out_ready;
        adv_c    = b_vld_reg && ready_c;
        ready_b  = !b_vld_reg || ready_c;
        adv_b    = a_vld_reg && ready_b;
        in_ready = !a_vld_reg || ready_b;
        accept   = in_valid && in_ready;

        a_vld_next   = accept ? 1'b1 : (adv_b ? 1'b0 : a_vld_reg);
        b_vld_next   = adv_b  ? 1'b1 : (adv_c ? 1'b0 : b_vld_reg);
        out_vld_next = adv_c  ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg   <= a_vld_next;
            b_vld_reg   <= b_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // capture the transaction
    always_ff @(posedge clk)
    begin
        if (accept)
            smp_reg <= '{enc1_a: enc1_a, enc1_b: enc1_b, enc2_a: enc2_a,
                         enc2_b: enc2_b, tick: tick};
    end

    dqds_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (adv_b),
        .sample   (smp_reg),
        .interval (interval_reg),
        .trk      (trk)
    );

    dqds_speed u_speed (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (adv_c),
        .trk           (trk),
        .scale         (scale_reg),
        .count_one     (cnt_one_w),
        .count_two     (cnt_two_w),
        .speed_one     (spd_one_w),
        .speed_two     (spd_two_w),
        .speed_updated (speed_updated)
    );

    assign out_valid = out_vld_reg;
    assign count_one = $signed(cnt_one_w);
    assign count_two = $signed(cnt_two_w);
    assign speed_one = $signed(spd_one_w);
    assign speed_two = $signed(spd_two_w);

`ifndef NO_ASSERTIONS
    // back-pressure only when every stage holds a transaction
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (a_vld_reg && b_vld_reg && out_valid && !out_ready))
        else $error("in_ready dropped with room in the pipeline");

    // speeds move only on a result that carries an update
    a_speed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(speed_one) || !$stable(speed_two)) |-> (speed_updated && out_valid))
        else $error("speed changed without an update");
`endif

endmodule

### tb/dual_quadrature_decoder_speed_top_tb.sv
module dual_quadrature_decoder_speed_top_tb;
    import dqds_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 4;
    localparam int LATENCY      = 3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int CHUNKS       = 4;
    localparam int MAX_PRINTS   = 50;

    localparam logic signed [64:0] SPEED_MAX = 65'sd2147483647;
    localparam logic signed [64:0] SPEED_MIN = -65'sd2147483648;
    localparam logic [ScaleW-1:0]  SCALE_MAX    = '1;
    localparam logic [TickW-1:0]   INTERVAL_MAX = '1;

    // Walks every one of the 16 {previous, current} pairs, starting from the reset state.
    localparam logic [1:0] TRANSITION_WALK [17] = '{
        2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0, 2'd3,
        2'd1, 2'd3, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3
    };

    typedef struct packed {
        logic [CountW-1:0] count_one;
        logic [CountW-1:0] count_two;
        logic [CountW-1:0] speed_one;
        logic [CountW-1:0] speed_two;
        logic              updated;
    } reading_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [0:0]        cfg_index = REG_INTERVAL;
    logic [CfgW-1:0]   cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              enc1_a    = 1'b0;
    logic              enc1_b    = 1'b0;
    logic              enc2_a    = 1'b0;
    logic              enc2_b    = 1'b0;
    logic              tick      = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic signed [CountW-1:0] count_one;
    logic signed [CountW-1:0] count_two;
    logic signed [CountW-1:0] speed_one;
    logic signed [CountW-1:0] speed_two;
    logic              speed_updated;

    // Decoder state as predicted from the accepted samples
    logic [TickW-1:0]  cfg_interval = INTERVAL_RESET;
    logic [ScaleW-1:0] cfg_scale    = SCALE_RESET;
    logic [1:0]        enc_one_prev = ENC_STATE_RESET;
    logic [1:0]        enc_two_prev = ENC_STATE_RESET;
    logic [CountW-1:0] pos_one  = '0;
    logic [CountW-1:0] pos_two  = '0;
    logic [CountW-1:0] snap_one = '0;
    logic [CountW-1:0] snap_two = '0;
    logic [CountW-1:0] vel_one  = '0;
    logic [CountW-1:0] vel_two  = '0;
    logic [TickW-1:0]  tick_count = '0;

    reading_t pending_readings[$];
    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    dual_quadrature_decoder_speed_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .enc1_a        (enc1_a),
        .enc1_b        (enc1_b),
        .enc2_a        (enc2_a),
        .enc2_b        (enc2_b),
        .tick          (tick),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .count_one     (count_one),
        .count_two     (count_two),
        .speed_one     (speed_one),
        .speed_two     (speed_two),
        .speed_updated (speed_updated)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Position of a state along the counting-up cycle 00, 01, 11, 10 (self-inverse map)
    function automatic logic [1:0] gray_rank(input logic [1:0] s);
        return {s[1], s[1] ^ s[0]};
    endfunction

    function automatic logic [1:0] gray_step(input logic [1:0] cur, input logic up);
        logic [1:0] r;
        r = gray_rank(cur);
        r = up ? r + 2'd1 : r - 2'd1;
        return gray_rank(r);
    endfunction

    function automatic logic [CountW-1:0] track_position(input logic [CountW-1:0] pos,
                                                         input logic [1:0] prev,
                                                         input logic [1:0] cur);
        logic [1:0] moved;
        moved = gray_rank(cur) - gray_rank(prev);
        // one step either way counts; no change or a double-bit jump holds
        case (moved)
            2'd1:    return pos + CountW'(1);
            2'd3:    return pos - CountW'(1);
            default: return pos;
        endcase
    endfunction

    function automatic logic [CountW-1:0] scaled_speed(input logic [CountW-1:0] now,
                                                       input logic [CountW-1:0] then);
        logic signed [CountW-1:0] delta;
        logic signed [64:0]       product;
        delta   = now - then;
        product = delta * $signed({1'b0, cfg_scale});
        if (product > SPEED_MAX)
            return SPEED_MAX[CountW-1:0];
        if (product < SPEED_MIN)
            return SPEED_MIN[CountW-1:0];
        return product[CountW-1:0];
    endfunction

    function automatic reading_t predict_reading(input sample_t s);
        reading_t         r;
        logic [TickW:0]   next_count;
        logic [TickW-1:0] limit;
        pos_one      = track_position(pos_one, enc_one_prev, {s.enc1_a, s.enc1_b});
        enc_one_prev = {s.enc1_a, s.enc1_b};
        pos_two      = track_position(pos_two, enc_two_prev, {s.enc2_a, s.enc2_b});
        enc_two_prev = {s.enc2_a, s.enc2_b};
        r.updated = 1'b0;
        if (s.tick)
        begin
            next_count = {1'b0, tick_count} + (TickW+1)'(1);
            limit      = (cfg_interval == '0) ? TickW'(1) : cfg_interval;
            if (next_count >= {1'b0, limit})
            begin
                vel_one    = scaled_speed(pos_one, snap_one);
                vel_two    = scaled_speed(pos_two, snap_two);
                snap_one   = pos_one;
                snap_two   = pos_two;
                tick_count = '0;
                r.updated  = 1'b1;
            end
            else
                tick_count = next_count[TickW-1:0];
        end
        r.count_one = pos_one;
        r.count_two = pos_two;
        r.speed_one = vel_one;
        r.speed_two = vel_two;
        return r;
    endfunction

    function automatic sample_t make_sample(input logic [1:0] one, input logic [1:0] two,
                                            input logic tk);
        return '{one[1], one[0], two[1], two[0], tk};
    endfunction

    task automatic report_error(input string what, input logic [CountW-1:0] got,
                                input logic [CountW-1:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("cycle %0d: %s: got %h, want %h", cycle_count, what, got, want);
    endtask

    task automatic send_sample(input sample_t s);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        enc1_a   <= s.enc1_a;
        enc1_b   <= s.enc1_b;
        enc2_a   <= s.enc2_a;
        enc2_b   <= s.enc2_b;
        tick     <= s.tick;
        do
            @(posedge clk);
        while (!in_ready);
        pending_readings.push_back(predict_reading(s));
    endtask

    // Drop valid, wait for every pending result, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic configure(input logic [TickW-1:0] interval, input logic [ScaleW-1:0] scale);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INTERVAL;
        cfg_data  <= CfgW'(interval);
        @(posedge clk);
        cfg_index <= REG_SCALE;
        cfg_data  <= scale;
        @(posedge clk);
        cfg_we       <= 1'b0;
        cfg_interval = interval;
        cfg_scale    = scale;
    endtask

    task automatic test_every_transition();
        // encoder two runs the same walk backwards, which covers every pair as well
        for (int i = 1; i <= 16; i++)
            send_sample(make_sample(TRANSITION_WALK[i], TRANSITION_WALK[16 - i], i[0]));
        settle();
    endtask

    task automatic test_zero_interval_saturation();
        configure('0, SCALE_MAX);
        // every tick updates, and any one-edge move saturates at full scale
        for (int i = 0; i < 4; i++)
            send_sample(make_sample(gray_step(enc_one_prev, i < 2),
                                    gray_step(enc_two_prev, i >= 2), 1'b1));
        settle();
    endtask

    task automatic test_interval_lowered();
        configure(INTERVAL_MAX, SCALE_RESET);
        for (int i = 0; i < 4; i++)
            send_sample(make_sample(gray_step(enc_one_prev, 1'b1), enc_two_prev, 1'b1));
        settle();
        // running count already past the new interval: next tick updates at once
        configure(TickW'(3), SCALE_RESET);
        send_sample(make_sample(gray_step(enc_one_prev, 1'b1),
                                gray_step(enc_two_prev, 1'b0), 1'b1));
        send_sample(make_sample(enc_one_prev, enc_two_prev, 1'b1));
        settle();
    endtask

    task automatic test_random(input int items, input int send_pct, input int recv_pct);
        logic             dir_one;
        logic             dir_two;
        logic [TickW-1:0] interval;
        logic [ScaleW-1:0] scale;
        int               tick_pct;
        logic [1:0]       next_one;
        logic [1:0]       next_two;
        int               pick;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        dir_one = 1'b1;
        dir_two = 1'b0;
        for (int chunk = 0; chunk < CHUNKS; chunk++)
        begin
            case (chunk)
                0:
                begin
                    interval = TickW'(1);
                    scale    = '0;
                end
                1:
                begin
                    interval = '0;
                    scale    = SCALE_MAX;
                end
                default:
                begin
                    case ($urandom_range(3))
                        0:       interval = TickW'($urandom_range(2, 6));
                        1:       interval = TickW'($urandom_range(7, 40));
                        2:       interval = INTERVAL_MAX;
                        default: interval = TickW'($urandom_range(1, 16));
                    endcase
                    case ($urandom_range(3))
                        0:       scale = SCALE_RESET;
                        1:       scale = $urandom;
                        2:       scale = SCALE_MAX;
                        default: scale = $urandom_range(1, 32'h0010_0000);
                    endcase
                end
            endcase
            settle();
            configure(interval, scale);
            tick_pct = $urandom_range(15, 100);
            for (int i = 0; i < items / CHUNKS; i++)
            begin
                if ($urandom_range(99) < 4)
                    dir_one = !dir_one;
                if ($urandom_range(99) < 4)
                    dir_two = !dir_two;
                // mostly clean quadrature motion, some holds, some arbitrary jumps
                pick = $urandom_range(99);
                if (pick < 72)
                    next_one = gray_step(enc_one_prev, dir_one);
                else if (pick < 90)
                    next_one = enc_one_prev;
                else
                    next_one = 2'($urandom_range(3));
                pick = $urandom_range(99);
                if (pick < 72)
                    next_two = gray_step(enc_two_prev, dir_two);
                else if (pick < 90)
                    next_two = enc_two_prev;
                else
                    next_two = 2'($urandom_range(3));
                send_sample(make_sample(next_one, next_two, $urandom_range(99) < tick_pct));
            end
        end
        settle();
    endtask

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_readings.size() == 0)
                report_error("result with no transaction pending", count_one, '0);
            else
            begin
                want = pending_readings.pop_front();
                if (count_one !== want.count_one)
                    report_error("count_one", count_one, want.count_one);
                if (count_two !== want.count_two)
                    report_error("count_two", count_two, want.count_two);
                if (speed_one !== want.speed_one)
                    report_error("speed_one", speed_one, want.speed_one);
                if (speed_two !== want.speed_two)
                    report_error("speed_two", speed_two, want.speed_two);
                if (speed_updated !== want.updated)
                    report_error("speed_updated", CountW'(speed_updated),
                                 CountW'(want.updated));
            end
        end
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("dual_quadrature_decoder_speed_top_tb: errors");
            $finish;
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_every_transition();
        test_zero_interval_saturation();
        test_interval_lowered();
        test_random(RANDOM_ITEMS / 3, 28, 52);
        test_random(RANDOM_ITEMS / 3, 52, 28);
        test_random(RANDOM_ITEMS / 3, 0, 0);
        if (error_count == 0)
            $display("dual_quadrature_decoder_speed_top_tb: clean");
        else
            $display("dual_quadrature_decoder_speed_top_tb: errors");
        $finish;
    end

endmodule

### filelist.f
src/dqds_pkg.sv
src/dqds_track.sv
src/dqds_speed.sv
src/dual_quadrature_decoder_speed_top.sv
tb/dual_quadrature_decoder_speed_top_tb.sv
